// ===== sv/tofp_pkg.sv =====
// Shared types, codes and fade helpers of the tracked object fade table.
`timescale 1ns / 1ps
package tofp_pkg;

    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned KCNT_W      = 5;
    localparam logic [16:0] ONE_Q16     = 17'h10000;

    // Result kinds
    localparam logic [2:0] KIND_SNAP     = 3'd0;
    localparam logic [2:0] KIND_RELEASED = 3'd1;
    localparam logic [2:0] KIND_ACTIVE   = 3'd2;
    localparam logic [2:0] KIND_DROPPED  = 3'd3;
    localparam logic [2:0] KIND_EMPTY    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_FADE_IN  = 2'd0;
    localparam logic [1:0] REG_FADE_OUT = 2'd1;
    localparam logic [1:0] REG_HOLD     = 2'd2;
    localparam logic [1:0] REG_GRACE    = 2'd3;

    typedef enum logic [2:0] {
        OP_FRAME_START = 3'd0,
        OP_OBSERVE     = 3'd1,
        OP_FRAME_END   = 3'd2,
        OP_TICK        = 3'd3,
        OP_SNAPSHOT    = 3'd4,
        OP_SWEEP       = 3'd5,
        OP_ACTIVE      = 3'd6
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_IN,
        ST_DIV_OUT,
        ST_DIV_TICK,
        ST_SNAP_RD,
        ST_SNAP_MUL,
        ST_SNAP_ADD,
        ST_SWEEP,
        ST_FLUSH
    } st_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_t;

    typedef struct packed {
        op_t         op;
        logic [47:0] now_us;
        logic [15:0] samples;
        logic [15:0] id;
        logic [15:0] label;
        pos_t        pos;
        logic [16:0] factor;
    } cmd_t;

    typedef struct packed {
        logic [15:0] fade_in;
        logic [15:0] fade_out;
        logic [31:0] hold_us;
        logic [31:0] grace_us;
    } cfg_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] label;
        pos_t        prev;
        pos_t        cur;
        logic [16:0] fade;
        logic [47:0] last_us;
    } entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] id;
        logic [15:0] label;
        logic [16:0] fade;
        pos_t        pos;
        logic        is_active;
        logic        last;
    } res_t;

    // Fade in, saturating at one
    function automatic logic [16:0] fade_add(input logic [16:0] a, input logic [16:0] b);
        logic [17:0] s;
        s = {1'b0, a} + {1'b0, b};
        fade_add = (s > {1'b0, ONE_Q16}) ? ONE_Q16 : s[16:0];
    endfunction

    // Fade out, saturating at zero
    function automatic logic [16:0] fade_sub(input logic [16:0] a, input logic [16:0] b);
        fade_sub = (a > b) ? (a - b) : 17'd0;
    endfunction

endpackage

// ===== sv/tofp_if.sv =====
// Item and result channel interfaces of the tracked object fade table.
`timescale 1ns / 1ps
interface tofp_item_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [47:0]        now_us;
    logic [15:0]        update_samples;
    logic [15:0]        object_id;
    logic [15:0]        object_label;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               position_valid;
    logic [16:0]        interp_factor;

    modport source (
        output valid, mode, now_us, update_samples, object_id, object_label,
               pos_x, pos_y, pos_z, position_valid, interp_factor,
        input  ready
    );
    modport sink (
        input  valid, mode, now_us, update_samples, object_id, object_label,
               pos_x, pos_y, pos_z, position_valid, interp_factor,
        output ready
    );
endinterface

interface tofp_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         result_kind;
    logic [15:0]        result_id;
    logic [15:0]        result_label;
    logic [16:0]        result_fade;
    logic signed [31:0] interp_x;
    logic signed [31:0] interp_y;
    logic signed [31:0] interp_z;
    logic               is_active;
    logic               last_of_run;

    modport source (
        output valid, result_kind, result_id, result_label, result_fade,
               interp_x, interp_y, interp_z, is_active, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, result_kind, result_id, result_label, result_fade,
               interp_x, interp_y, interp_z, is_active, last_of_run,
        output ready
    );
endinterface

// ===== sv/tofp_front.sv =====
// Front end: accepts items, decodes the mode and drops items that do nothing.
`timescale 1ns / 1ps
module tofp_front (
    tofp_item_if.sink     item,
    input  logic          q_full,
    output logic          push,
    output tofp_pkg::cmd_t cmd
);
    import tofp_pkg::*;

    logic keep;

    // Decode mode; unknown mode and invalid observations are consumed silently
    always_comb
    begin
        cmd.op = OP_FRAME_START;
        keep   = 1'b1;
        unique case (item.mode)
            OP_FRAME_START: cmd.op = OP_FRAME_START;
            OP_OBSERVE:
            begin
                cmd.op = OP_OBSERVE;
                keep   = item.position_valid;
            end
            OP_FRAME_END: cmd.op = OP_FRAME_END;
            OP_TICK:      cmd.op = OP_TICK;
            OP_SNAPSHOT:  cmd.op = OP_SNAPSHOT;
            OP_SWEEP:     cmd.op = OP_SWEEP;
            OP_ACTIVE:    cmd.op = OP_ACTIVE;
            default: keep = 1'b0;
        endcase
    end

    // Carry payload; clamp the blend factor to one
    always_comb
    begin
        cmd.now_us  = item.now_us;
        cmd.samples = item.update_samples;
        cmd.id      = item.object_id;
        cmd.label   = item.object_label;
        cmd.pos.x   = item.pos_x;
        cmd.pos.y   = item.pos_y;
        cmd.pos.z   = item.pos_z;
        cmd.factor  = (item.interp_factor > ONE_Q16) ? ONE_Q16 : item.interp_factor;
    end

    assign item.ready = !q_full;
    assign push       = item.valid && !q_full && keep;

endmodule

// ===== sv/tofp_queue.sv =====
// Two-entry command queue between the front end and the table engine.
`timescale 1ns / 1ps
module tofp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tofp_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           head_valid,
    output tofp_pkg::cmd_t head_cmd,
    input  logic           pop
);
    import tofp_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/tofp_div.sv =====
// Radix-2 restoring divider for fade steps: (samples << 16) / total, capped at one.
`timescale 1ns / 1ps
module tofp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] samples,
    input  logic [15:0] total,
    output logic        done,
    output logic [16:0] step
);
    import tofp_pkg::*;

    logic [31:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    // One quotient bit per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]};
        if (start)
        begin
            quo_next  = {samples, 16'd0};
            rem_next  = 16'd0;
            dvs_next  = (total == 16'd0) ? 16'd1 : total;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 16'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign step = (quo_reg > {15'd0, ONE_Q16}) ? ONE_Q16 : quo_reg[16:0];

endmodule

// ===== sv/tofp_back.sv =====
// Table engine: keeps the sorted object table and carries out each command.
`timescale 1ns / 1ps
module tofp_back #(
    parameter int unsigned DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tofp_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  tofp_pkg::cmd_t q_cmd,
    output logic           pop,
    tofp_result_if.source  result
);
    import tofp_pkg::*;

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    st_t state_reg, state_next;

    entry_t             ent_reg  [DEPTH];
    entry_t             ent_next [DEPTH];
    logic [DEPTH-1:0]   used_reg, used_next;
    logic [DEPTH-1:0]   seen_reg, seen_next;
    logic [16:0]        step_in_reg, step_in_next;
    logic [16:0]        step_out_reg, step_out_next;
    cmd_t               cmd_reg;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   w_reg, w_next;
    logic [KCNT_W-1:0]  k_reg, k_next;

    res_t res_reg, pend_reg, new_res;
    res_t res_next, pend_next;
    logic res_valid_reg, pend_valid_reg;
    logic res_valid_next, pend_valid_next;

    // Snapshot pipeline registers
    logic [15:0]        sn_id_reg, sn_label_reg;
    logic [16:0]        sn_fade_reg;
    pos_t               sn_prev_reg;
    logic signed [32:0] diff_reg [3];
    logic signed [50:0] prod_reg [3];

    // Divider hookup
    logic        div_start, div_done;
    logic [15:0] div_samples, div_total;
    logic [16:0] div_step;

    // Controls
    logic out_free, at_end, snap_end, stale;
    logic emit_new, do_flush, do_observe, do_frame_end, do_tick, do_clear_seen;
    logic snap_load, snap_mul, sweep_move, sweep_finish;

    entry_t           rd_ent;
    logic             rd_seen;
    logic [IDX_W-1:0] rd_idx;
    logic [47:0]      age_us;

    // Observe match and insertion point
    logic [DEPTH-1:0] lt, eq, ins;
    logic             any_eq, full, any_active;

    tofp_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .samples (div_samples),
        .total   (div_total),
        .done    (div_done),
        .step    (div_step)
    );

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sh07FFFFFFF)
        begin
            sat32 = 32'sh7FFFFFFF;
        end
        else if (v < -36'sh080000000)
        begin
            sat32 = -32'sh80000000;
        end
        else
        begin
            sat32 = v[31:0];
        end
    endfunction

    assign out_free = !res_valid_reg || result.ready;
    assign rd_idx   = idx_reg[IDX_W-1:0];
    assign rd_ent   = ent_reg[rd_idx];
    assign rd_seen  = seen_reg[rd_idx];
    assign at_end   = (idx_reg == CNT_W'(DEPTH)) || !used_reg[rd_idx];
    assign snap_end = at_end || (k_reg == KCNT_W'(MAX_RESULTS));
    assign age_us   = cmd_reg.now_us - rd_ent.last_us;
    assign stale    = (k_reg != KCNT_W'(MAX_RESULTS)) && !rd_seen &&
                      (rd_ent.fade == 17'd0) && (cmd_reg.now_us > rd_ent.last_us) &&
                      (age_us > {16'd0, cfg.grace_us});

    // Compare the head id against every entry
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            lt[i] = used_reg[i] && (ent_reg[i].id < q_cmd.id);
            eq[i] = used_reg[i] && (ent_reg[i].id == q_cmd.id);
        end
        ins[0] = !lt[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            ins[i] = !lt[i] && lt[i-1];
        end
        any_eq     = |eq;
        full       = used_reg[DEPTH-1];
        any_active = |(eq & seen_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_FRAME_START: state_next = ST_DIV_IN;
                        OP_OBSERVE:     state_next = (full && !any_eq) ? ST_FLUSH : ST_IDLE;
                        OP_FRAME_END:   state_next = ST_IDLE;
                        OP_TICK:        state_next = ST_DIV_TICK;
                        OP_SNAPSHOT:    state_next = ST_SNAP_RD;
                        OP_SWEEP:       state_next = ST_SWEEP;
                        OP_ACTIVE:      state_next = ST_FLUSH;
                        default:        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV_IN:   if (div_done) state_next = ST_DIV_OUT;
            ST_DIV_OUT:  if (div_done) state_next = ST_IDLE;
            ST_DIV_TICK: if (div_done) state_next = ST_IDLE;
            ST_SNAP_RD:
            begin
                if (snap_end)
                begin
                    state_next = ST_FLUSH;
                end
                else if (rd_ent.fade != 17'd0)
                begin
                    state_next = ST_SNAP_MUL;
                end
            end
            ST_SNAP_MUL: state_next = ST_SNAP_ADD;
            ST_SNAP_ADD: if (out_free) state_next = ST_SNAP_RD;
            ST_SWEEP:    if (at_end) state_next = ST_FLUSH;
            ST_FLUSH:    if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        pop           = 1'b0;
        div_start     = 1'b0;
        div_samples   = cmd_reg.samples;
        div_total     = cfg.fade_out;
        emit_new      = 1'b0;
        do_flush      = 1'b0;
        do_observe    = 1'b0;
        do_frame_end  = 1'b0;
        do_tick       = 1'b0;
        do_clear_seen = 1'b0;
        snap_load     = 1'b0;
        snap_mul      = 1'b0;
        sweep_move    = 1'b0;
        sweep_finish  = 1'b0;
        new_res       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop         = q_valid;
                div_samples = q_cmd.samples;
                div_total   = (q_cmd.op == OP_FRAME_START) ? cfg.fade_in : cfg.fade_out;
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_FRAME_START, OP_TICK: div_start = 1'b1;
                        OP_OBSERVE:
                        begin
                            if (full && !any_eq)
                            begin
                                emit_new    = 1'b1;
                                new_res.kind = KIND_DROPPED;
                                new_res.id   = q_cmd.id;
                            end
                            else
                            begin
                                do_observe = 1'b1;
                            end
                        end
                        OP_FRAME_END: do_frame_end = 1'b1;
                        OP_ACTIVE:
                        begin
                            emit_new          = 1'b1;
                            new_res.kind      = KIND_ACTIVE;
                            new_res.id        = q_cmd.id;
                            new_res.is_active = any_active;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV_IN:
            begin
                div_start = div_done;
            end
            ST_DIV_OUT:
            begin
                do_clear_seen = div_done;
            end
            ST_DIV_TICK:
            begin
                do_tick       = div_done;
                do_clear_seen = div_done;
            end
            ST_SNAP_RD:
            begin
                snap_load = !snap_end && (rd_ent.fade != 17'd0);
            end
            ST_SNAP_MUL:
            begin
                snap_mul = 1'b1;
            end
            ST_SNAP_ADD:
            begin
                emit_new      = out_free;
                new_res.kind  = KIND_SNAP;
                new_res.id    = sn_id_reg;
                new_res.label = sn_label_reg;
                new_res.fade  = sn_fade_reg;
                new_res.pos.x = sat32(36'(sn_prev_reg.x) + 36'($signed(prod_reg[0][50:16])));
                new_res.pos.y = sat32(36'(sn_prev_reg.y) + 36'($signed(prod_reg[1][50:16])));
                new_res.pos.z = sat32(36'(sn_prev_reg.z) + 36'($signed(prod_reg[2][50:16])));
            end
            ST_SWEEP:
            begin
                if (at_end)
                begin
                    sweep_finish = 1'b1;
                end
                else if (stale)
                begin
                    emit_new     = out_free;
                    new_res.kind = KIND_RELEASED;
                    new_res.id   = rd_ent.id;
                end
                else
                begin
                    sweep_move = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                do_flush = out_free;
            end
            default: ;
        endcase
    end

    // Table update
    always_comb
    begin
        used_next     = used_reg;
        seen_next     = seen_reg;
        step_in_next  = step_in_reg;
        step_out_next = step_out_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            ent_next[i] = ent_reg[i];
        end
        if (state_reg == ST_DIV_IN && div_done)
        begin
            step_in_next = div_step;
        end
        if (state_reg == ST_DIV_OUT && div_done)
        begin
            step_out_next = div_step;
        end
        if (do_clear_seen)
        begin
            seen_next = '0;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (do_observe)
            begin
                if (any_eq)
                begin
                    if (eq[i])
                    begin
                        ent_next[i].fade    = fade_add(ent_reg[i].fade, step_in_reg);
                        ent_next[i].prev    = ent_reg[i].cur;
                        ent_next[i].cur     = q_cmd.pos;
                        ent_next[i].label   = q_cmd.label;
                        ent_next[i].last_us = q_cmd.now_us;
                        seen_next[i]        = 1'b1;
                    end
                end
                else if (ins[i])
                begin
                    ent_next[i].id      = q_cmd.id;
                    ent_next[i].label   = q_cmd.label;
                    ent_next[i].prev    = q_cmd.pos;
                    ent_next[i].cur     = q_cmd.pos;
                    ent_next[i].fade    = fade_add(17'd0, step_in_reg);
                    ent_next[i].last_us = q_cmd.now_us;
                    used_next[i]        = 1'b1;
                    seen_next[i]        = 1'b1;
                end
                else if (!lt[i] && i > 0)
                begin
                    // shift toward the end to open the insertion slot
                    ent_next[i]  = ent_reg[(i > 0) ? i - 1 : 0];
                    used_next[i] = used_reg[(i > 0) ? i - 1 : 0];
                    seen_next[i] = seen_reg[(i > 0) ? i - 1 : 0];
                end
            end
            if (do_frame_end && used_reg[i] && !seen_reg[i])
            begin
                ent_next[i].fade = fade_sub(ent_reg[i].fade, step_out_reg);
            end
            if (do_tick && used_reg[i])
            begin
                if (!((cfg.hold_us != 32'd0) && (cmd_reg.now_us >= ent_reg[i].last_us) &&
                      ((cmd_reg.now_us - ent_reg[i].last_us) <= {16'd0, cfg.hold_us})))
                begin
                    ent_next[i].fade = fade_sub(ent_reg[i].fade, div_step);
                end
            end
            if (sweep_move && (w_reg == CNT_W'(i)))
            begin
                ent_next[i]  = rd_ent;
                seen_next[i] = rd_seen;
            end
            if (sweep_finish && (CNT_W'(i) >= w_reg))
            begin
                used_next[i] = 1'b0;
                seen_next[i] = 1'b0;
            end
        end
    end

    // Walk counters
    always_comb
    begin
        idx_next = idx_reg;
        w_next   = w_reg;
        k_next   = k_reg;
        if (state_reg == ST_IDLE)
        begin
            idx_next = '0;
            w_next   = '0;
            k_next   = '0;
        end
        if (state_reg == ST_SNAP_RD && !snap_end && rd_ent.fade == 17'd0)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (state_reg == ST_SNAP_ADD && out_free)
        begin
            idx_next = idx_reg + CNT_W'(1);
            k_next   = k_reg + KCNT_W'(1);
        end
        if (state_reg == ST_SWEEP && !at_end)
        begin
            if (stale)
            begin
                if (out_free)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    k_next   = k_reg + KCNT_W'(1);
                end
            end
            else
            begin
                idx_next = idx_reg + CNT_W'(1);
                w_next   = w_reg + CNT_W'(1);
            end
        end
    end

    // Hold one result back so the final one of a run can carry the last mark
    always_comb
    begin
        res_valid_next  = res_valid_reg && !result.ready;
        pend_valid_next = pend_valid_reg;
        res_next        = res_reg;
        pend_next       = pend_reg;
        if (emit_new)
        begin
            pend_valid_next = 1'b1;
            pend_next       = new_res;
            if (pend_valid_reg)
            begin
                res_valid_next = 1'b1;
                res_next       = pend_reg;
                res_next.last  = 1'b0;
            end
        end
        if (do_flush)
        begin
            pend_valid_next = 1'b0;
            res_valid_next  = 1'b1;
            if (pend_valid_reg)
            begin
                res_next = pend_reg;
            end
            else
            begin
                res_next      = '0;
                res_next.kind = KIND_EMPTY;
            end
            res_next.last = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            seen_reg       <= '0;
            step_in_reg    <= '0;
            step_out_reg   <= '0;
            idx_reg        <= '0;
            w_reg          <= '0;
            k_reg          <= '0;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            seen_reg       <= seen_next;
            step_in_reg    <= step_in_next;
            step_out_reg   <= step_out_next;
            idx_reg        <= idx_next;
            w_reg          <= w_next;
            k_reg          <= k_next;
            res_valid_reg  <= res_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ent_reg[i] <= ent_next[i];
        end
        if (pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (snap_load)
        begin
            sn_id_reg    <= rd_ent.id;
            sn_label_reg <= rd_ent.label;
            sn_fade_reg  <= rd_ent.fade;
            sn_prev_reg  <= rd_ent.prev;
            diff_reg[0]  <= 33'(rd_ent.cur.x) - 33'(rd_ent.prev.x);
            diff_reg[1]  <= 33'(rd_ent.cur.y) - 33'(rd_ent.prev.y);
            diff_reg[2]  <= 33'(rd_ent.cur.z) - 33'(rd_ent.prev.z);
        end
        if (snap_mul)
        begin
            for (int a = 0; a < 3; a++)
            begin
                prod_reg[a] <= 51'(diff_reg[a] * $signed({1'b0, cmd_reg.factor}));
            end
        end
        res_reg  <= res_next;
        pend_reg <= pend_next;
    end

    assign result.valid        = res_valid_reg;
    assign result.result_kind  = res_reg.kind;
    assign result.result_id    = res_reg.id;
    assign result.result_label = res_reg.label;
    assign result.result_fade  = res_reg.fade;
    assign result.interp_x     = res_reg.pos.x;
    assign result.interp_y     = res_reg.pos.y;
    assign result.interp_z     = res_reg.pos.z;
    assign result.is_active    = res_reg.is_active;
    assign result.last_of_run  = res_reg.last;

endmodule

// ===== sv/tracked_object_fade_table.sv =====
// Top level of the tracked object fade table: configuration registers and the two halves.
`timescale 1ns / 1ps
// Keeps up to TABLE_DEPTH tracked objects sorted by id and runs frame, observe,
// tick, snapshot, release sweep and active query items. A two-entry queue sits
// between the accepting front end and the table engine, and results leave
// through a registered output stage. A tick waits for one run of the bit-serial
// fade step divider and a frame start for two (fade-in step, then fade-out
// step); each division shifts out 32 quotient bits. A snapshot skips faded-out
// entries one per cycle and passes each listed entry through the read, multiply
// and add steps of the blend, waiting while the output is busy; a release sweep
// visits the entries in turn. The user must write configuration through
// cfg_we, cfg_index and cfg_data while the block is idle; nothing enforces it.
module tracked_object_fade_table #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    tofp_item_if.sink     item,
    tofp_result_if.source result
);
    import tofp_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t push_cmd, head_cmd;
    logic push, q_full, head_valid, pop;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FADE_IN:  cfg_next.fade_in  = cfg_data[15:0];
                REG_FADE_OUT: cfg_next.fade_out = cfg_data[15:0];
                REG_HOLD:     cfg_next.hold_us  = cfg_data;
                REG_GRACE:    cfg_next.grace_us = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fade_in  <= 16'd480;
            cfg_reg.fade_out <= 16'd4800;
            cfg_reg.hold_us  <= 32'd0;
            cfg_reg.grace_us <= 32'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tofp_front u_front (
        .item   (item),
        .q_full (q_full),
        .push   (push),
        .cmd    (push_cmd)
    );

    tofp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    tofp_back #(
        .DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (head_valid),
        .q_cmd   (head_cmd),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the tracked object fade table.
`timescale 1ns / 1ps
module tb_top;
    import tofp_pkg::*;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [2:0]         kind;
        logic [15:0]        id;
        logic [15:0]        label;
        logic [16:0]        fade;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               active;
        logic               last;
    } outcome_t;

    typedef struct {
        logic [15:0]        id;
        logic [15:0]        label;
        logic signed [31:0] prev [3];
        logic signed [31:0] cur [3];
        logic [16:0]        fade;
        logic               seen;
        logic [47:0]        last_us;
    } track_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    tofp_item_if   item_ch ();
    tofp_result_if res_ch ();

    tracked_object_fade_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch.sink),
        .result    (res_ch.source)
    );

    // Shadow table state
    track_t      tracks [$];
    logic [16:0] step_in_q;
    logic [16:0] step_out_q;
    logic [15:0] fade_in_cfg;
    logic [15:0] fade_out_cfg;
    logic [31:0] hold_cfg;
    logic [31:0] grace_cfg;

    outcome_t expected_q [$];
    int  errors;
    int  items_sent;
    int  results_seen;
    int  idle_cycles;
    bit  calm;
    logic [47:0] clock_us;

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [16:0] step_for(logic [15:0] samples, logic [15:0] total);
        logic [31:0] d;
        logic [31:0] s;
        d = (total == 0) ? 32'd1 : {16'd0, total};
        s = {samples, 16'd0} / d;
        return (s > 32'h10000) ? 17'h10000 : s[16:0];
    endfunction

    function automatic logic signed [31:0] blend_axis(logic signed [31:0] p,
                                                      logic signed [31:0] c,
                                                      logic [16:0] f);
        longint prod;
        longint q;
        longint r;
        prod = (longint'(c) - longint'(p)) * longint'({15'd0, f});
        q = (prod >= 0) ? prod / 65536 : -((-prod + 65535) / 65536);
        r = longint'(p) + q;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic outcome_t blank(logic [2:0] kind, logic [15:0] id);
        outcome_t o;
        o.kind = kind;
        o.id = id;
        o.label = '0;
        o.fade = '0;
        o.x = '0;
        o.y = '0;
        o.z = '0;
        o.active = 1'b0;
        o.last = 1'b0;
        return o;
    endfunction

    // Advance the shadow table by one item and queue the results it causes
    task automatic predict_item(op_t op, logic [47:0] now, logic [15:0] samples,
                                logic [15:0] id, logic [15:0] label,
                                logic signed [31:0] px, logic signed [31:0] py,
                                logic signed [31:0] pz, logic pv, logic [16:0] factor);
        int pos;
        int cnt;
        logic [16:0] st;
        logic [16:0] f;
        logic [17:0] sum;
        logic hold;
        outcome_t o;
        outcome_t batch [$];
        track_t t;
        track_t kept [$];
        case (op)
            OP_FRAME_START:
            begin
                foreach (tracks[i]) tracks[i].seen = 1'b0;
                step_in_q = step_for(samples, fade_in_cfg);
                step_out_q = step_for(samples, fade_out_cfg);
            end
            OP_OBSERVE:
            begin
                if (pv)
                begin
                    pos = 0;
                    while (pos < tracks.size() && tracks[pos].id < id) pos++;
                    if (pos < tracks.size() && tracks[pos].id == id)
                    begin
                        sum = {1'b0, tracks[pos].fade} + {1'b0, step_in_q};
                        tracks[pos].prev = tracks[pos].cur;
                        tracks[pos].fade = (sum > 18'h10000) ? 17'h10000 : sum[16:0];
                    end
                    else if (tracks.size() >= DEPTH)
                    begin
                        o = blank(KIND_DROPPED, id);
                        o.last = 1'b1;
                        expected_q.insert(expected_q.size(), o);
                        return;
                    end
                    else
                    begin
                        t.id = id;
                        t.prev[0] = px;
                        t.prev[1] = py;
                        t.prev[2] = pz;
                        t.cur = t.prev;
                        t.fade = step_in_q;
                        t.seen = 1'b0;
                        t.label = '0;
                        t.last_us = '0;
                        tracks.insert(pos, t);
                    end
                    tracks[pos].label = label;
                    tracks[pos].cur[0] = px;
                    tracks[pos].cur[1] = py;
                    tracks[pos].cur[2] = pz;
                    tracks[pos].seen = 1'b1;
                    tracks[pos].last_us = now;
                end
            end
            OP_FRAME_END:
            begin
                foreach (tracks[i])
                    if (!tracks[i].seen)
                        tracks[i].fade = (tracks[i].fade > step_out_q) ?
                                         tracks[i].fade - step_out_q : 17'd0;
            end
            OP_TICK:
            begin
                st = step_for(samples, fade_out_cfg);
                foreach (tracks[i])
                begin
                    tracks[i].seen = 1'b0;
                    hold = (hold_cfg != 0) && (now >= tracks[i].last_us) &&
                           (now - tracks[i].last_us <= {16'd0, hold_cfg});
                    if (!hold)
                        tracks[i].fade = (tracks[i].fade > st) ? tracks[i].fade - st : 17'd0;
                end
            end
            OP_SNAPSHOT:
            begin
                f = (factor > 17'h10000) ? 17'h10000 : factor;
                foreach (tracks[i])
                begin
                    if (batch.size() < MAX_RESULTS && tracks[i].fade != 0)
                    begin
                        o = blank(KIND_SNAP, tracks[i].id);
                        o.label = tracks[i].label;
                        o.fade = tracks[i].fade;
                        o.x = blend_axis(tracks[i].prev[0], tracks[i].cur[0], f);
                        o.y = blend_axis(tracks[i].prev[1], tracks[i].cur[1], f);
                        o.z = blend_axis(tracks[i].prev[2], tracks[i].cur[2], f);
                        batch.insert(batch.size(), o);
                    end
                end
            end
            OP_SWEEP:
            begin
                cnt = 0;
                foreach (tracks[i])
                begin
                    if (cnt < MAX_RESULTS && !tracks[i].seen && tracks[i].fade == 0 &&
                        now > tracks[i].last_us &&
                        now - tracks[i].last_us > {16'd0, grace_cfg})
                    begin
                        batch.insert(batch.size(), blank(KIND_RELEASED, tracks[i].id));
                        cnt++;
                    end
                    else
                        kept.insert(kept.size(), tracks[i]);
                end
                tracks = kept;
            end
            OP_ACTIVE:
            begin
                o = blank(KIND_ACTIVE, id);
                foreach (tracks[i])
                    if (tracks[i].id == id) o.active = tracks[i].seen;
                batch.insert(batch.size(), o);
            end
            default:
            begin
            end
        endcase
        if (op == OP_SNAPSHOT || op == OP_SWEEP)
            if (batch.size() == 0) batch.insert(0, blank(KIND_EMPTY, 16'd0));
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) expected_q.insert(expected_q.size(), batch[i]);
    endtask

    // Drive one item, hold it until the transfer, then predict it
    task automatic send_item(logic [2:0] mode, logic [47:0] now, logic [15:0] samples,
                             logic [15:0] id, logic [15:0] label,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz, logic pv, logic [16:0] factor);
        while (!calm && $urandom_range(99) < 34)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.mode <= mode;
        item_ch.now_us <= now;
        item_ch.update_samples <= samples;
        item_ch.object_id <= id;
        item_ch.object_label <= label;
        item_ch.pos_x <= px;
        item_ch.pos_y <= py;
        item_ch.pos_z <= pz;
        item_ch.position_valid <= pv;
        item_ch.interp_factor <= factor;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        predict_item(op_t'(mode), now, samples, id, label, px, py, pz, pv, factor);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_op(op_t op, logic [15:0] samples, logic [15:0] id);
        send_item(op, clock_us, samples, id, $urandom, $urandom, $urandom, $urandom,
                  1'b1, $urandom_range(65536));
    endtask

    task automatic observe(logic [15:0] id, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic pv);
        send_item(OP_OBSERVE, clock_us, $urandom, id, $urandom, x, y, z, pv, $urandom);
    endtask

    // Stop driving and wait for the block to drain before a register write
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (expected_q.size() > 0) @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FADE_IN:  fade_in_cfg = val[15:0];
            REG_FADE_OUT: fade_out_cfg = val[15:0];
            REG_HOLD:     hold_cfg = val;
            default:      grace_cfg = val;
        endcase
        @(negedge clk);
    endtask

    task automatic test_directed_edges();
        send_op(OP_SNAPSHOT, 0, 0);
        send_op(OP_SWEEP, 0, 0);
        send_op(OP_ACTIVE, 0, 16'hFFFF);
        send_op(OP_FRAME_START, 16'hFFFF, 0);
        observe(16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b1);
        observe(16'h0000, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1);
        observe(16'h1234, 32'h1, 32'h2, 32'h3, 1'b0);
        observe(16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h12345678, 1'b1);
        send_op(OP_ACTIVE, 0, 16'hFFFF);
        send_op(OP_ACTIVE, 0, 16'h1234);
        send_item(OP_SNAPSHOT, clock_us, 0, 0, 0, 0, 0, 0, 1'b1, 17'h1FFFF);
        send_item(OP_SNAPSHOT, clock_us, 0, 0, 0, 0, 0, 0, 1'b1, 17'h08000);
        send_op(OP_FRAME_END, 0, 0);
        send_op(OP_FRAME_START, 16'd0, 0);
        send_op(OP_FRAME_END, 0, 0);
        clock_us = clock_us + 1000;
        send_op(OP_TICK, 16'hFFFF, 0);
        send_op(OP_SWEEP, 0, 0);
        send_item(7, clock_us, 0, 0, 0, 0, 0, 0, 1'b1, 0);
        send_op(OP_SNAPSHOT, 0, 0);
    endtask

    task automatic test_table_full();
        send_op(OP_FRAME_START, 16'd100, 0);
        for (int i = 0; i < 20; i++)
            observe(16'(i * 37 + 5), $urandom, $urandom, $urandom, 1'b1);
        send_op(OP_FRAME_END, 0, 0);
        send_item(OP_SNAPSHOT, clock_us, 0, 0, 0, 0, 0, 0, 1'b1, 17'h10000);
        clock_us = clock_us + 50;
        send_op(OP_TICK, 16'hFFFF, 0);
        clock_us = clock_us + 50;
        send_op(OP_SWEEP, 0, 0);
    endtask

    // Frames with random content, plus noise items
    task automatic test_random_frames(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            clock_us = clock_us + $urandom_range(40000);
            if ($urandom_range(99) < 75)
            begin
                send_op(OP_FRAME_START, $urandom_range(2000), 0);
                n++;
                repeat ($urandom_range(6))
                begin
                    observe(16'($urandom_range(40)), $urandom, $urandom, $urandom,
                            $urandom_range(9) != 0);
                    n++;
                end
                send_op(OP_FRAME_END, 0, 0);
                n++;
            end
            case ($urandom_range(5))
                0: send_op(OP_TICK, $urandom, 0);
                1: send_op(OP_SWEEP, 0, 0);
                2: send_op(OP_ACTIVE, 0, $urandom_range(40));
                3: observe($urandom, $urandom, $urandom, $urandom, $urandom);
                4: send_item($urandom_range(7), $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom);
                default: send_op(OP_SNAPSHOT, 0, 0);
            endcase
            n++;
        end
    endtask

    task automatic test_config_extremes();
        drain();
        write_reg(REG_FADE_IN, 32'd1);
        write_reg(REG_FADE_OUT, 32'd65535);
        write_reg(REG_HOLD, 32'hFFFFFFFF);
        write_reg(REG_GRACE, 32'hFFFFFFFF);
        test_random_frames(60);
        drain();
        write_reg(REG_FADE_IN, 32'd65535);
        write_reg(REG_FADE_OUT, 32'd1);
        write_reg(REG_HOLD, 32'd20000);
        write_reg(REG_GRACE, 32'd0);
        test_random_frames(60);
        drain();
        write_reg(REG_FADE_IN, 32'd0);
        write_reg(REG_FADE_OUT, 32'd300);
        write_reg(REG_HOLD, 32'd0);
        write_reg(REG_GRACE, 32'd30000);
        test_random_frames(80);
    endtask

    // Result side: random stall, then compare each transfer
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= calm || ($urandom_range(99) >= 34);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d id %0d", $time,
                         res_ch.result_kind, res_ch.result_id);
                errors++;
            end
            else
            begin
                outcome_t e;
                e = expected_q.pop_front();
                if (e.kind !== res_ch.result_kind || e.id !== res_ch.result_id ||
                    e.label !== res_ch.result_label || e.fade !== res_ch.result_fade ||
                    e.x !== res_ch.interp_x || e.y !== res_ch.interp_y ||
                    e.z !== res_ch.interp_z || e.active !== res_ch.is_active ||
                    e.last !== res_ch.last_of_run)
                begin
                    $display("%0t: mismatch exp kind %0d id %0d lbl %0d fade %0d xyz %0d %0d %0d act %0d last %0d",
                             $time, e.kind, e.id, e.label, e.fade, e.x, e.y, e.z,
                             e.active, e.last);
                    $display("%0t:          got kind %0d id %0d lbl %0d fade %0d xyz %0d %0d %0d act %0d last %0d",
                             $time, res_ch.result_kind, res_ch.result_id,
                             res_ch.result_label, res_ch.result_fade, res_ch.interp_x,
                             res_ch.interp_y, res_ch.interp_z, res_ch.is_active,
                             res_ch.last_of_run);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.mode = '0;
        item_ch.now_us = '0;
        item_ch.update_samples = '0;
        item_ch.object_id = '0;
        item_ch.object_label = '0;
        item_ch.pos_x = '0;
        item_ch.pos_y = '0;
        item_ch.pos_z = '0;
        item_ch.position_valid = 1'b0;
        item_ch.interp_factor = '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        calm = 1'b0;
        clock_us = 48'd1000;
        fade_in_cfg = 16'd480;
        fade_out_cfg = 16'd4800;
        hold_cfg = 0;
        grace_cfg = 0;
        step_in_q = '0;
        step_out_q = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_table_full();
        test_random_frames(140);
        calm = 1'b1;
        test_random_frames(40);
        calm = 1'b0;
        test_config_extremes();

        item_ch.valid <= 1'b0;
        while (expected_q.size() > 0) @(negedge clk);
        repeat (200) @(negedge clk);
        $display("Covered %0d items and %0d results over four register settings,",
                 items_sent, results_seen);
        $display("including a full table, empty lists and unknown modes.");
        if (errors == 0 && expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
